### sv/lhp_pkg.sv
// Shared types, widths, pipeline timing and helpers for the line hit point block.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package lhp_pkg;

   localparam int CW     = 32;             // coordinate width
   localparam int FB     = 16;             // fraction bits
   localparam int SO_W   = CW - 1;         // standoff register width
   localparam int DIF_W  = CW + 1;         // coordinate differences
   localparam int UVW_W  = CW + 2;         // direction terms, may be negated differences
   localparam int PRD_W  = 2 * UVW_W;      // products and dot sums
   localparam int NSPLIT = PRD_W / 2;      // split point of the wide multiply
   localparam int DVD_W  = PRD_W + DIF_W;  // dividend width
   localparam int DVS_W  = PRD_W;          // divisor width
   localparam int OFP_W  = SO_W + 1 + UVW_W;
   localparam int QB     = CW + 4;         // quotient bits before overflow
   localparam int QO_W   = QB + 2;
   localparam int ACC_W  = QO_W + 2;
   localparam int SQR_W  = PRD_W + 2 * FB; // radicand width
   localparam int RT_W   = SQR_W / 2;      // root width
   localparam int REM_W  = RT_W + 2;

   // pipeline timing, counted in register stages after acceptance
   localparam int K_SQ     = 3;
   localparam int K_DIV    = 5;
   localparam int SQ_LAT   = RT_W;
   localparam int DIV_LAT  = QB + 3;
   localparam int K_OFS_IN = K_SQ + SQ_LAT;
   localparam int K_FIN    = K_OFS_IN + DIV_LAT;
   localparam int PIPE_LAT = K_FIN + 1;

   localparam logic [SO_W-1:0] STANDOFF_RST = SO_W'(6554);

   typedef logic signed [CW-1:0]    coord_type;
   typedef logic signed [DIF_W-1:0] dif_type;
   typedef logic signed [UVW_W-1:0] uvw_type;
   typedef logic signed [PRD_W-1:0] prd_type;
   typedef logic signed [DVD_W-1:0] dvd_type;
   typedef logic signed [DVS_W-1:0] dvs_type;
   typedef logic signed [OFP_W-1:0] ofp_type;
   typedef logic signed [QO_W-1:0]  quo_type;
   typedef logic signed [ACC_W-1:0] acc_type;
   typedef logic [RT_W-1:0]         root_type;

   localparam coord_type CMAX = {1'b0, {(CW-1){1'b1}}};
   localparam coord_type CMIN = {1'b1, {(CW-1){1'b0}}};

   typedef struct packed {
      quo_type quo;
      logic    ovf;   // quotient magnitude beyond QB bits
      logic    neg;   // sign of the true quotient
   } div_res_type;

   function automatic coord_type sat_coord(acc_type v);
      coord_type r;
      if (v > acc_type'(CMAX)) r = CMAX;
      else if (v < acc_type'(CMIN)) r = CMIN;
      else r = coord_type'(v);
      return r;
   endfunction

endpackage
`default_nettype wire

### sv/lhp_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on lhp_pkg for the coordinate type.
`default_nettype none
interface lhp_req_if;
   import lhp_pkg::*;
   logic      valid;
   logic      ready;
   logic      req_type;
   coord_type ref_ax;
   coord_type ref_ay;
   coord_type ref_az;
   coord_type ref_bx;
   coord_type ref_bz;
   coord_type player_x;
   coord_type player_y;
   coord_type player_z;
   coord_type bullet_x;
   coord_type bullet_y;
   coord_type bullet_z;
   modport source (output valid, req_type, ref_ax, ref_ay, ref_az, ref_bx, ref_bz,
                   player_x, player_y, player_z, bullet_x, bullet_y, bullet_z,
                   input ready);
   modport sink (input valid, req_type, ref_ax, ref_ay, ref_az, ref_bx, ref_bz,
                 player_x, player_y, player_z, bullet_x, bullet_y, bullet_z,
                 output ready);
endinterface

interface lhp_rsp_if;
   import lhp_pkg::*;
   logic      valid;
   logic      ready;
   coord_type hit_x;
   coord_type hit_y;
   coord_type hit_z;
   logic      no_intersection;
   modport source (output valid, hit_x, hit_y, hit_z, no_intersection, input ready);
   modport sink (input valid, hit_x, hit_y, hit_z, no_intersection, output ready);
endinterface
`default_nettype wire

### sv/lhp_sqrt.sv
// Pipelined floor square root, one root bit per stage.
// Depends on lhp_pkg for widths.
`default_nettype none
module lhp_sqrt (
   input  logic               clock,
   input  logic               ce,
   input  lhp_pkg::prd_type   radicand,
   output lhp_pkg::root_type  root
);
   import lhp_pkg::*;

   logic [SQR_W-1:0] x_ff    [RT_W-1];
   logic [REM_W-1:0] rem_ff  [RT_W];
   logic [RT_W-1:0]  root_ff [RT_W];

   for (genvar j = 0; j < RT_W; j++) begin : g_st
      logic [SQR_W-1:0] x_prev;
      logic [REM_W-1:0] rem_prev;
      logic [RT_W-1:0]  root_prev;
      logic [REM_W+1:0] remx;
      logic [REM_W-1:0] trial;
      logic             ge;

      if (j == 0) begin : g_first
         assign x_prev    = {radicand, {(2*FB){1'b0}}};
         assign rem_prev  = '0;
         assign root_prev = '0;
      end else begin : g_next
         assign x_prev    = x_ff[j-1];
         assign rem_prev  = rem_ff[j-1];
         assign root_prev = root_ff[j-1];
      end

      always_comb begin
         remx  = {rem_prev, x_prev[SQR_W-1 -: 2]};
         trial = {root_prev, 2'b01};
         ge    = remx >= {2'b00, trial};
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            rem_ff[j]  <= ge ? REM_W'(remx - {2'b00, trial}) : remx[REM_W-1:0];
            root_ff[j] <= {root_prev[RT_W-2:0], ge};
         end
      end

      if (j < RT_W - 1) begin : g_x
         always_ff @(posedge clock) begin
            if (ce) begin
               x_ff[j] <= x_prev << 2;
            end
         end
      end
   end

   assign root = root_ff[RT_W-1];

endmodule
`default_nettype wire

### sv/lhp_div.sv
// Pipelined signed restoring divider, rounding to nearest with ties away from zero.
// One quotient bit per stage; flags quotients too large for QB bits. Uses lhp_pkg.
`default_nettype none
module lhp_div (
   input  logic                  clock,
   input  logic                  ce,
   input  lhp_pkg::dvd_type      dividend,
   input  lhp_pkg::dvs_type      divisor,
   output lhp_pkg::div_res_type  result
);
   import lhp_pkg::*;

   logic [DVD_W-1:0] nmag_ff;
   logic [DVS_W-1:0] dmag_ff;
   logic             neg0_ff;

   logic [DVS_W-1:0] rem_ff [QB+1];
   logic [QB-1:0]    nlo_ff [QB+1];
   logic [QB-1:0]    quo_ff [QB+1];
   logic [DVS_W-1:0] dm_ff  [QB+1];
   logic             ovf_ff [QB+1];
   logic             sgn_ff [QB+1];

   div_res_type      res_ff;
   logic             rnd_inc;
   logic [QB:0]      qmag;

   // magnitudes and sign
   always_ff @(posedge clock) begin
      if (ce) begin
         nmag_ff <= dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
         dmag_ff <= divisor[DVS_W-1] ? DVS_W'(-divisor) : DVS_W'(divisor);
         neg0_ff <= dividend[DVD_W-1] ^ divisor[DVS_W-1];
      end
   end

   // overflow check, remainder seeded with the high dividend bits
   always_ff @(posedge clock) begin
      if (ce) begin
         rem_ff[0] <= {{(DVS_W-(DVD_W-QB)){1'b0}}, nmag_ff[DVD_W-1:QB]};
         nlo_ff[0] <= nmag_ff[QB-1:0];
         quo_ff[0] <= '0;
         dm_ff[0]  <= dmag_ff;
         ovf_ff[0] <= {{(DVS_W-(DVD_W-QB)){1'b0}}, nmag_ff[DVD_W-1:QB]} >= dmag_ff;
         sgn_ff[0] <= neg0_ff;
      end
   end

   for (genvar i = 1; i <= QB; i++) begin : g_it
      logic [DVS_W:0] trial;
      logic           ge;

      always_comb begin
         trial = {rem_ff[i-1], nlo_ff[i-1][QB-1]};
         ge    = trial >= {1'b0, dm_ff[i-1]};
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            rem_ff[i] <= ge ? DVS_W'(trial - {1'b0, dm_ff[i-1]}) : trial[DVS_W-1:0];
            nlo_ff[i] <= {nlo_ff[i-1][QB-2:0], 1'b0};
            quo_ff[i] <= {quo_ff[i-1][QB-2:0], ge};
            dm_ff[i]  <= dm_ff[i-1];
            ovf_ff[i] <= ovf_ff[i-1];
            sgn_ff[i] <= sgn_ff[i-1];
         end
      end
   end

   // round half away from zero, then apply sign
   always_comb begin
      rnd_inc = {rem_ff[QB], 1'b0} >= {1'b0, dm_ff[QB]};
      qmag    = {1'b0, quo_ff[QB]} + (QB+1)'(rnd_inc);
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         res_ff.quo <= sgn_ff[QB] ? -quo_type'(qmag) : quo_type'(qmag);
         res_ff.ovf <= ovf_ff[QB];
         res_ff.neg <= sgn_ff[QB];
      end
   end

   assign result = res_ff;

endmodule
`default_nettype wire

### sv/line_hit_point_2d.sv
// Top level of the line hit point block: request/result channels, standoff register,
// feed pipeline, square root and divider instances. Uses lhp_pkg, lhp_if, lhp_sqrt, lhp_div.
//
// Usage:
//   req_chan carries one request (mode, target or wall points, player and bullet
//   positions, signed Q16.16). rsp_chan returns one result per request, in order:
//   the saturated hit point and the no_intersection flag.
//   csr_wr_en/csr_wr_data write the 31-bit standoff distance (reset 6554 = 0.1);
//   write it only while no request is in flight.
//   A request passes the feed stages, then the 50-stage square root (one root bit
//   per stage) followed by the 39-stage offset divider (one quotient bit per
//   stage) and the final stage; the line divisions run alongside.
//   Throughput is one request per cycle while the result channel is not stalled.
//   The whole pipeline advances on one enable: a full output register that is not
//   taken holds every stage, so req_chan.ready drops and nothing is lost or repeated.
//   A synchronous reset clears all valid bits and restores the standoff register;
//   req_chan.ready stays low while reset is high.
`default_nettype none
module line_hit_point_2d (
   input  logic                         clock,
   input  logic                         reset,
   lhp_req_if.sink                      req_chan,
   lhp_rsp_if.source                    rsp_chan,
   input  logic                         csr_wr_en,
   input  logic [lhp_pkg::SO_W-1:0]     csr_wr_data
);
   import lhp_pkg::*;

   localparam int D_OD = K_OFS_IN - 4;          // offset dividend delay
   localparam int D_SD = K_FIN - 4;             // side info delay
   localparam int D_Q  = K_FIN - (K_DIV + DIV_LAT);

   typedef struct packed {
      coord_type bul_x;
      coord_type bul_y;
      coord_type bul_z;
      coord_type ply_x;
      coord_type ply_z;
   } side_type;

   typedef struct packed {
      side_type side;
      logic     den_zero;   // parallel lines
      logic     len_zero;   // no offset direction
   } sd_type;

   typedef struct packed {
      dif_type  dx;
      dif_type  dz;
      dif_type  tx;
      dif_type  tz;
      uvw_type  u;
      uvw_type  v;
      uvw_type  w;
      logic     neg;
      side_type side;
   } s1_type;

   typedef struct packed {
      prd_type  pd_a;
      prd_type  pd_b;
      prd_type  pn_a;
      prd_type  pn_b;
      prd_type  pl_a;
      prd_type  pl_b;
      prd_type  pl_c;
      dif_type  dx;
      dif_type  dz;
      uvw_type  cx;
      uvw_type  cy;
      uvw_type  cz;
      side_type side;
   } s2_type;

   typedef struct packed {
      prd_type  den;
      prd_type  num;
      prd_type  len;
      dif_type  dx;
      dif_type  dz;
      uvw_type  cx;
      uvw_type  cy;
      uvw_type  cz;
      side_type side;
   } s3_type;

   typedef struct packed {
      prd_type ml_x;
      prd_type mh_x;
      prd_type ml_z;
      prd_type mh_z;
      prd_type den;
      ofp_type op_x;
      ofp_type op_y;
      ofp_type op_z;
      sd_type  sd;
   } s4_type;

   typedef struct packed {
      dvd_type dvd_x;
      dvd_type dvd_z;
      prd_type den;
   } s5_type;

   typedef struct packed {
      dvd_type x;
      dvd_type y;
      dvd_type z;
   } ofs_dvd_type;

   typedef struct packed {
      div_res_type qx;
      div_res_type qz;
   } qpair_type;

   typedef struct packed {
      coord_type hit_x;
      coord_type hit_y;
      coord_type hit_z;
      logic      no_intersection;
   } rsp_type;

   logic                ce;
   logic [PIPE_LAT-1:0] vld_ff;
   logic [SO_W-1:0]     standoff_ff;

   s1_type      s1_ff, s1_in;
   s2_type      s2_ff, s2_in;
   s3_type      s3_ff, s3_in;
   s4_type      s4_ff, s4_in;
   s5_type      s5_ff, s5_in;
   ofs_dvd_type od_ff [D_OD];
   sd_type      sd_ff [D_SD];
   qpair_type   q_ff  [D_Q];
   rsp_type     rsp_ff, rsp_in;

   root_type    root;
   div_res_type qx_res, qz_res, ox_res, oy_res, oz_res;

   dif_type     ex, ez;
   quo_type     ox_eff, oy_eff, oz_eff;
   sd_type      sd_fin;
   qpair_type   q_fin;

   // Global stage enable: everything moves unless a finished result is held.
   assign ce             = ~vld_ff[PIPE_LAT-1] | rsp_chan.ready;
   assign req_chan.ready = ce & ~reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         standoff_ff <= STANDOFF_RST;
      end else begin
         if (ce) begin
            vld_ff <= {vld_ff[PIPE_LAT-2:0], req_chan.valid};
         end
         if (csr_wr_en) begin
            standoff_ff <= csr_wr_data;
         end
      end
   end

   // Stage 1: differences. Both modes reduce to num = t.(u,v), den = d.(u,v),
   // L = u^2 + v^2 + w^2 with (u,v,w) = target offset or wall normal terms.
   always_comb begin
      s1_in.dx = dif_type'(req_chan.bullet_x) - dif_type'(req_chan.player_x);
      s1_in.dz = dif_type'(req_chan.bullet_z) - dif_type'(req_chan.player_z);
      s1_in.tx = dif_type'(req_chan.ref_ax) - dif_type'(req_chan.player_x);
      s1_in.tz = dif_type'(req_chan.ref_az) - dif_type'(req_chan.player_z);
      ex       = dif_type'(req_chan.ref_bx) - dif_type'(req_chan.ref_ax);
      ez       = dif_type'(req_chan.ref_bz) - dif_type'(req_chan.ref_az);
      if (req_chan.req_type) begin
         s1_in.u = uvw_type'(ez);
         s1_in.v = -uvw_type'(ex);
         s1_in.w = '0;
      end else begin
         s1_in.u = uvw_type'(s1_in.tx);
         s1_in.v = uvw_type'(s1_in.tz);
         s1_in.w = uvw_type'(dif_type'(req_chan.ref_ay) - dif_type'(req_chan.player_y));
      end
      s1_in.neg        = ~req_chan.req_type;   // target mode pulls back toward the player
      s1_in.side.bul_x = req_chan.bullet_x;
      s1_in.side.bul_y = req_chan.bullet_y;
      s1_in.side.bul_z = req_chan.bullet_z;
      s1_in.side.ply_x = req_chan.player_x;
      s1_in.side.ply_z = req_chan.player_z;
   end

   // Stage 2: products
   always_comb begin
      s2_in.pd_a = s1_ff.dx * s1_ff.u;
      s2_in.pd_b = s1_ff.dz * s1_ff.v;
      s2_in.pn_a = s1_ff.tx * s1_ff.u;
      s2_in.pn_b = s1_ff.tz * s1_ff.v;
      s2_in.pl_a = s1_ff.u * s1_ff.u;
      s2_in.pl_b = s1_ff.v * s1_ff.v;
      s2_in.pl_c = s1_ff.w * s1_ff.w;
      s2_in.dx   = s1_ff.dx;
      s2_in.dz   = s1_ff.dz;
      s2_in.cx   = s1_ff.neg ? -s1_ff.u : s1_ff.u;
      s2_in.cy   = s1_ff.neg ? -s1_ff.w : s1_ff.w;
      s2_in.cz   = s1_ff.neg ? -s1_ff.v : s1_ff.v;
      s2_in.side = s1_ff.side;
   end

   // Stage 3: dot sums
   always_comb begin
      s3_in.den  = s2_ff.pd_a + s2_ff.pd_b;
      s3_in.num  = s2_ff.pn_a + s2_ff.pn_b;
      s3_in.len  = s2_ff.pl_a + s2_ff.pl_b + s2_ff.pl_c;
      s3_in.dx   = s2_ff.dx;
      s3_in.dz   = s2_ff.dz;
      s3_in.cx   = s2_ff.cx;
      s3_in.cy   = s2_ff.cy;
      s3_in.cz   = s2_ff.cz;
      s3_in.side = s2_ff.side;
   end

   // Stage 4: num*d as two partial products, standoff*direction, zero flags
   always_comb begin
      s4_in.ml_x        = $signed({1'b0, s3_ff.num[NSPLIT-1:0]}) * s3_ff.dx;
      s4_in.mh_x        = $signed(s3_ff.num[PRD_W-1:NSPLIT]) * s3_ff.dx;
      s4_in.ml_z        = $signed({1'b0, s3_ff.num[NSPLIT-1:0]}) * s3_ff.dz;
      s4_in.mh_z        = $signed(s3_ff.num[PRD_W-1:NSPLIT]) * s3_ff.dz;
      s4_in.den         = s3_ff.den;
      s4_in.op_x        = $signed({1'b0, standoff_ff}) * s3_ff.cx;
      s4_in.op_y        = $signed({1'b0, standoff_ff}) * s3_ff.cy;
      s4_in.op_z        = $signed({1'b0, standoff_ff}) * s3_ff.cz;
      s4_in.sd.side     = s3_ff.side;
      s4_in.sd.den_zero = s3_ff.den == '0;
      s4_in.sd.len_zero = s3_ff.len == '0;
   end

   // Stage 5: recombine the wide dividends
   always_comb begin
      s5_in.dvd_x = (dvd_type'(s4_ff.mh_x) <<< NSPLIT) + dvd_type'(s4_ff.ml_x);
      s5_in.dvd_z = (dvd_type'(s4_ff.mh_z) <<< NSPLIT) + dvd_type'(s4_ff.ml_z);
      s5_in.den   = s4_ff.den;
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
      end
   end

   // Delay lines that line operands up with the square root and divider latency
   always_ff @(posedge clock) begin
      if (ce) begin
         od_ff[0].x <= dvd_type'(s4_ff.op_x) <<< FB;
         od_ff[0].y <= dvd_type'(s4_ff.op_y) <<< FB;
         od_ff[0].z <= dvd_type'(s4_ff.op_z) <<< FB;
         for (int i = 1; i < D_OD; i++) od_ff[i] <= od_ff[i-1];
         sd_ff[0] <= s4_ff.sd;
         for (int i = 1; i < D_SD; i++) sd_ff[i] <= sd_ff[i-1];
         q_ff[0].qx <= qx_res;
         q_ff[0].qz <= qz_res;
         for (int i = 1; i < D_Q; i++) q_ff[i] <= q_ff[i-1];
      end
   end

   // Line intersection quotients: num*d / den
   lhp_div u_div_x (.clock(clock), .ce(ce), .dividend(s5_ff.dvd_x), .divisor(s5_ff.den),
                    .result(qx_res));
   lhp_div u_div_z (.clock(clock), .ce(ce), .dividend(s5_ff.dvd_z), .divisor(s5_ff.den),
                    .result(qz_res));

   // Direction length in Q.32 for normalizing the standoff
   lhp_sqrt u_sqrt (.clock(clock), .ce(ce), .radicand(s3_ff.len), .root(root));

   lhp_div u_div_ox (.clock(clock), .ce(ce), .dividend(od_ff[D_OD-1].x),
                     .divisor(dvs_type'(root)), .result(ox_res));
   lhp_div u_div_oy (.clock(clock), .ce(ce), .dividend(od_ff[D_OD-1].y),
                     .divisor(dvs_type'(root)), .result(oy_res));
   lhp_div u_div_oz (.clock(clock), .ce(ce), .dividend(od_ff[D_OD-1].z),
                     .divisor(dvs_type'(root)), .result(oz_res));

   // Final stage: hit x/z = player + quotient + offset, y = bullet y + offset, saturated;
   // parallel lines return the bullet. An oversized quotient saturates in its own direction.
   always_comb begin
      sd_fin = sd_ff[D_SD-1];
      q_fin  = q_ff[D_Q-1];
      ox_eff = sd_fin.len_zero ? '0 : ox_res.quo;
      oy_eff = sd_fin.len_zero ? '0 : oy_res.quo;
      oz_eff = sd_fin.len_zero ? '0 : oz_res.quo;
      rsp_in.no_intersection = sd_fin.den_zero;
      if (sd_fin.den_zero) begin
         rsp_in.hit_x = sd_fin.side.bul_x;
         rsp_in.hit_y = sd_fin.side.bul_y;
         rsp_in.hit_z = sd_fin.side.bul_z;
      end else begin
         if (q_fin.qx.ovf) begin
            rsp_in.hit_x = q_fin.qx.neg ? CMIN : CMAX;
         end else begin
            rsp_in.hit_x = sat_coord(acc_type'(sd_fin.side.ply_x) + acc_type'(q_fin.qx.quo)
                                     + acc_type'(ox_eff));
         end
         rsp_in.hit_y = sat_coord(acc_type'(sd_fin.side.bul_y) + acc_type'(oy_eff));
         if (q_fin.qz.ovf) begin
            rsp_in.hit_z = q_fin.qz.neg ? CMIN : CMAX;
         end else begin
            rsp_in.hit_z = sat_coord(acc_type'(sd_fin.side.ply_z) + acc_type'(q_fin.qz.quo)
                                     + acc_type'(oz_eff));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid           = vld_ff[PIPE_LAT-1];
   assign rsp_chan.hit_x           = rsp_ff.hit_x;
   assign rsp_chan.hit_y           = rsp_ff.hit_y;
   assign rsp_chan.hit_z           = rsp_ff.hit_z;
   assign rsp_chan.no_intersection = rsp_ff.no_intersection;

endmodule
`default_nettype wire
